@@ rtl/gans_pkg.sv @@
`default_nettype none

package gans_pkg;

   localparam int CELLS    = 4096;
   localparam int CELL_W   = 12;
   localparam int SIDE_W   = 6;
   localparam int CFG_W    = 7;
   localparam int COST_W   = 13;
   localparam int HEUR_W   = 7;
   localparam int SIDE_MAX = 64;

   localparam logic [COST_W-1:0] COST_NONE = '1;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   localparam logic REG_GRID_ROWS = 1'b0;
   localparam logic REG_GRID_COLS = 1'b1;

   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   typedef struct packed {
      logic              passable;
      logic [COST_W-1:0] cost;
      logic [CELL_W-1:0] parent;
      logic [SIDE_W-1:0] row;
      logic [SIDE_W-1:0] col;
   } cell_entry_type;

   typedef struct packed {
      logic [COST_W-1:0] pri;
      logic [CELL_W-1:0] node;
   } heap_entry_type;

   function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) r = CFG_W'(1);
      else if (v > CFG_W'(SIDE_MAX)) r = CFG_W'(SIDE_MAX);
      return r;
   endfunction

   function automatic logic [HEUR_W-1:0] manhattan(input logic [SIDE_W-1:0] r1,
                                                   input logic [SIDE_W-1:0] c1,
                                                   input logic [SIDE_W-1:0] r2,
                                                   input logic [SIDE_W-1:0] c2);
      logic [SIDE_W-1:0] dr;
      logic [SIDE_W-1:0] dc;
      dr = (r1 > r2) ? r1 - r2 : r2 - r1;
      dc = (c1 > c2) ? c1 - c2 : c2 - c1;
      return HEUR_W'(dr) + HEUR_W'(dc);
   endfunction

endpackage

`default_nettype wire

@@ rtl/grid_astar_next_step.sv @@
// A* path search on a 4-connected grid of up to 64 by 64 cells.
// Requests enter on start while busy is low. A load request writes one cell
// of the occupancy grid; it gives no result. A search
// request runs A* from start to goal with a Manhattan heuristic and gives one
// result: the first cell after start, the path length and a found flag.
// A search first checks the request and divides start and goal by the column
// count to find their rows and columns, then sweeps the cost memory, then for
// each popped cell sifts the heap down and for each opened neighbor sifts it
// up, then walks the parent chain from goal back to start.
// The heap memory with its two read ports sets the pace of each pop.
// The result appears on the rsp_ ports for one cycle with rsp_valid high;
// the receiver cannot stall, so it must take it in that cycle.
// After reset the block sweeps the whole cell memory to walls with busy high;
// configuration writes are taken during that sweep.
// grid_rows lies at byte address 0 and grid_cols at byte address 4.
`default_nettype none

module grid_astar_next_step
   import gans_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_type,
   input  wire logic [CELL_W-1:0] req_cell_index,
   input  wire logic              req_cell_open,
   input  wire logic [CELL_W-1:0] req_start_cell,
   input  wire logic [CELL_W-1:0] req_goal_cell,
   output logic                   rsp_valid,
   output logic [CELL_W-1:0]      rsp_next_cell,
   output logic [CELL_W-1:0]      rsp_path_length,
   output logic                   rsp_found
);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_CHECK, S_DIV_GO, S_DIV_WAIT, S_CLEAR, S_CLEAR_END,
      S_POP, S_POP_D, S_SD_RD, S_SD_CMP, S_CUR, S_CUR_D, S_NB, S_NB_D,
      S_PU, S_PU_CMP, S_WALK_RD, S_WALK_D
   } state_type;

   state_type         state_ff;
   logic [CFG_W-1:0]  grid_rows_ff;
   logic [CFG_W-1:0]  grid_cols_ff;
   logic [CELL_W-1:0] cnt_ff;
   logic              clr_v_ff;
   logic [CELL_W-1:0] clr_a_ff;
   logic [CELL_W-1:0] start_ff;
   logic [CELL_W-1:0] goal_ff;
   logic [CFG_W-1:0]  rows_ff;
   logic [CFG_W-1:0]  cols_ff;
   logic [COST_W-1:0] cells_ff;
   logic              phase_ff;
   logic [SIDE_W-1:0] srow_ff;
   logic [SIDE_W-1:0] scol_ff;
   logic [SIDE_W-1:0] grow_ff;
   logic [SIDE_W-1:0] gcol_ff;
   logic [COST_W-1:0] count_ff;
   logic [CELL_W-1:0] hole_ff;
   heap_entry_type    top_ff;
   heap_entry_type    last_ff;
   heap_entry_type    key_ff;
   logic [CELL_W-1:0] cur_ff;
   logic [COST_W-1:0] cur_cost_ff;
   logic [SIDE_W-1:0] cur_row_ff;
   logic [SIDE_W-1:0] cur_col_ff;
   logic [1:0]        k_ff;
   logic [CELL_W-1:0] nb_ff;
   logic [SIDE_W-1:0] nb_row_ff;
   logic [SIDE_W-1:0] nb_col_ff;
   logic [CELL_W-1:0] walk_ff;
   logic [COST_W-1:0] steps_ff;
   logic [COST_W-1:0] gcost_ff;
   logic              rsp_valid_ff;
   logic [CELL_W-1:0] rsp_next_cell_ff;
   logic [CELL_W-1:0] rsp_path_length_ff;
   logic              rsp_found_ff;

   cell_entry_type    cell_mem [CELLS];
   cell_entry_type    cm_rdata_ff;
   logic [CELL_W-1:0] cm_raddr;
   logic              cm_we;
   logic [CELL_W-1:0] cm_waddr;
   cell_entry_type    cm_wdata;

   heap_entry_type    heap_mem [CELLS];
   heap_entry_type    hp_rd0_ff;
   heap_entry_type    hp_rd1_ff;
   logic [CELL_W-1:0] hp_raddr0;
   logic [CELL_W-1:0] hp_raddr1;
   logic              hp_we;
   logic [CELL_W-1:0] hp_waddr;
   heap_entry_type    hp_wdata;

   logic              div_go;
   logic              div_done;
   logic [CELL_W-1:0] div_quo;
   logic [CFG_W-1:0]  div_rem;

   logic              accept;
   logic              cfg_write;
   logic [13:0]       cells_prod;
   logic [13:0]       sd_l;
   logic [13:0]       sd_r;
   logic              sd_pick_l;
   logic              sd_pick_r;
   logic              sd_move;
   heap_entry_type    sd_best_l;
   logic [CELL_W-1:0] sd_next;
   logic [CELL_W-1:0] hole_m1;
   logic [CELL_W-1:0] pu_parent;
   logic              pu_move;
   logic              nb_ok;
   logic [CELL_W-1:0] nb_addr;
   logic [SIDE_W-1:0] nb_row;
   logic [SIDE_W-1:0] nb_col;
   logic              nb_free;
   logic [COST_W-1:0] new_cost;
   logic [COST_W-1:0] new_pri;
   logic [COST_W-1:0] start_pri;

   assign accept    = start && (state_ff == S_IDLE);
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_GRID_COLS) ? {25'd0, grid_cols_ff} : {25'd0, grid_rows_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= CFG_W'(SIDE_MAX);
         grid_cols_ff <= CFG_W'(SIDE_MAX);
      end else if (cfg_write) begin
         if (paddr[2] == REG_GRID_ROWS) grid_rows_ff <= pwdata[CFG_W-1:0];
         else grid_cols_ff <= pwdata[CFG_W-1:0];
      end
   end

   gans_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (phase_ff ? goal_ff : start_ff),
      .divisor   (cols_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign div_go     = (state_ff == S_DIV_GO);
   assign cells_prod = rows_ff * cols_ff;

   assign sd_l      = {1'b0, hole_ff, 1'b1};
   assign sd_r      = sd_l + 14'd1;
   assign sd_pick_l = (sd_l < {1'b0, count_ff}) && (hp_rd0_ff < last_ff);
   assign sd_best_l = sd_pick_l ? hp_rd0_ff : last_ff;
   assign sd_pick_r = (sd_r < {1'b0, count_ff}) && (hp_rd1_ff < sd_best_l);
   assign sd_move   = sd_pick_l || sd_pick_r;
   assign sd_next   = sd_pick_r ? sd_r[CELL_W-1:0] : sd_l[CELL_W-1:0];

   assign hole_m1   = hole_ff - 1'b1;
   assign pu_parent = {1'b0, hole_m1[CELL_W-1:1]};
   assign pu_move   = hp_rd0_ff > key_ff;

   assign nb_free   = cm_rdata_ff.passable && (cm_rdata_ff.cost == COST_NONE);
   assign new_cost  = cur_cost_ff + 1'b1;
   assign new_pri   = new_cost + COST_W'(manhattan(nb_row_ff, nb_col_ff, grow_ff, gcol_ff));
   assign start_pri = COST_W'(manhattan(srow_ff, scol_ff, grow_ff, gcol_ff));

   always_comb begin
      nb_ok   = 1'b0;
      nb_addr = cur_ff;
      nb_row  = cur_row_ff;
      nb_col  = cur_col_ff;
      case (k_ff)
         DIR_RIGHT: begin
            nb_ok   = ({1'b0, cur_col_ff} + 1'b1) < cols_ff;
            nb_addr = cur_ff + 1'b1;
            nb_col  = cur_col_ff + 1'b1;
         end
         DIR_LEFT: begin
            nb_ok   = cur_col_ff != '0;
            nb_addr = cur_ff - 1'b1;
            nb_col  = cur_col_ff - 1'b1;
         end
         DIR_DOWN: begin
            nb_ok   = ({1'b0, cur_row_ff} + 1'b1) < rows_ff;
            nb_addr = cur_ff + CELL_W'(cols_ff);
            nb_row  = cur_row_ff + 1'b1;
         end
         default: begin
            nb_ok   = cur_row_ff != '0;
            nb_addr = cur_ff - CELL_W'(cols_ff);
            nb_row  = cur_row_ff - 1'b1;
         end
      endcase
   end

   always_comb begin
      cm_raddr  = '0;
      cm_we     = 1'b0;
      cm_waddr  = '0;
      cm_wdata  = '{passable: 1'b0, cost: COST_NONE, parent: '0, row: '0, col: '0};
      hp_raddr0 = '0;
      hp_raddr1 = '0;
      hp_we     = 1'b0;
      hp_waddr  = '0;
      hp_wdata  = key_ff;
      case (state_ff)
         S_INIT: begin
            cm_we    = 1'b1;
            cm_waddr = cnt_ff;
         end
         S_IDLE: begin
            if (accept && (req_type == REQ_LOAD)) begin
               cm_we             = 1'b1;
               cm_waddr          = req_cell_index;
               cm_wdata.passable = req_cell_open;
            end
         end
         S_CLEAR: cm_raddr = cnt_ff;
         S_CLEAR_END: begin
            hp_we    = 1'b1;
            hp_wdata = '{pri: start_pri, node: start_ff};
         end
         S_POP: hp_raddr1 = CELL_W'(count_ff - 1'b1);
         S_SD_RD: begin
            hp_raddr0 = sd_l[CELL_W-1:0];
            hp_raddr1 = sd_r[CELL_W-1:0];
         end
         S_SD_CMP: begin
            hp_we    = 1'b1;
            hp_waddr = hole_ff;
            hp_wdata = sd_move ? (sd_pick_r ? hp_rd1_ff : hp_rd0_ff) : last_ff;
         end
         S_CUR: cm_raddr = top_ff.node;
         S_NB: cm_raddr = nb_addr;
         S_NB_D: begin
            if (nb_free) begin
               cm_we    = 1'b1;
               cm_waddr = nb_ff;
               cm_wdata = '{passable: 1'b1, cost: new_cost, parent: cur_ff,
                            row: nb_row_ff, col: nb_col_ff};
            end
         end
         S_PU: begin
            if (hole_ff == '0) hp_we = 1'b1;
            else hp_raddr0 = pu_parent;
         end
         S_PU_CMP: begin
            hp_we    = 1'b1;
            hp_waddr = hole_ff;
            hp_wdata = pu_move ? hp_rd0_ff : key_ff;
         end
         S_WALK_RD: cm_raddr = walk_ff;
         default: ;
      endcase
      if (clr_v_ff) begin
         cm_we    = 1'b1;
         cm_waddr = clr_a_ff;
         cm_wdata = '{passable: cm_rdata_ff.passable,
                      cost: (clr_a_ff == start_ff) ? '0 : COST_NONE,
                      parent: start_ff, row: srow_ff, col: scol_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
      cm_rdata_ff <= cell_mem[cm_raddr];
   end

   always_ff @(posedge clock) begin
      if (hp_we) heap_mem[hp_waddr] <= hp_wdata;
      hp_rd0_ff <= heap_mem[hp_raddr0];
      hp_rd1_ff <= heap_mem[hp_raddr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         clr_v_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         clr_v_ff     <= 1'b0;
         case (state_ff)
            S_INIT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == '1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept && (req_type == REQ_SEARCH)) begin
                  start_ff <= req_start_cell;
                  goal_ff  <= req_goal_cell;
                  rows_ff  <= clamp_side(grid_rows_ff);
                  cols_ff  <= clamp_side(grid_cols_ff);
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               cells_ff <= COST_W'(cells_prod);
               phase_ff <= 1'b0;
               if (({2'b0, start_ff} >= cells_prod) || ({2'b0, goal_ff} >= cells_prod)) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_next_cell_ff   <= start_ff;
                  rsp_path_length_ff <= '0;
                  rsp_found_ff       <= 1'b0;
                  state_ff           <= S_IDLE;
               end else if (start_ff == goal_ff) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_next_cell_ff   <= start_ff;
                  rsp_path_length_ff <= '0;
                  rsp_found_ff       <= 1'b1;
                  state_ff           <= S_IDLE;
               end else begin
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_done) begin
                  if (!phase_ff) begin
                     srow_ff  <= div_quo[SIDE_W-1:0];
                     scol_ff  <= div_rem[SIDE_W-1:0];
                     phase_ff <= 1'b1;
                     state_ff <= S_DIV_GO;
                  end else begin
                     grow_ff  <= div_quo[SIDE_W-1:0];
                     gcol_ff  <= div_rem[SIDE_W-1:0];
                     cnt_ff   <= '0;
                     state_ff <= S_CLEAR;
                  end
               end
            end
            S_CLEAR: begin
               clr_v_ff <= 1'b1;
               clr_a_ff <= cnt_ff;
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == '1) state_ff <= S_CLEAR_END;
            end
            S_CLEAR_END: begin
               count_ff <= COST_W'(1);
               state_ff <= S_POP;
            end
            S_POP: begin
               if (count_ff == '0) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_next_cell_ff   <= start_ff;
                  rsp_path_length_ff <= '0;
                  rsp_found_ff       <= 1'b0;
                  state_ff           <= S_IDLE;
               end else begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_POP_D;
               end
            end
            S_POP_D: begin
               top_ff   <= hp_rd0_ff;
               last_ff  <= hp_rd1_ff;
               hole_ff  <= '0;
               state_ff <= (count_ff == '0) ? S_CUR : S_SD_RD;
            end
            S_SD_RD: state_ff <= S_SD_CMP;
            S_SD_CMP: begin
               if (sd_move) begin
                  hole_ff  <= sd_next;
                  state_ff <= S_SD_RD;
               end else begin
                  state_ff <= S_CUR;
               end
            end
            S_CUR: state_ff <= S_CUR_D;
            S_CUR_D: begin
               cur_ff      <= top_ff.node;
               cur_cost_ff <= cm_rdata_ff.cost;
               cur_row_ff  <= cm_rdata_ff.row;
               cur_col_ff  <= cm_rdata_ff.col;
               k_ff        <= DIR_RIGHT;
               if (top_ff.node == goal_ff) begin
                  gcost_ff <= cm_rdata_ff.cost;
                  walk_ff  <= goal_ff;
                  steps_ff <= '0;
                  state_ff <= S_WALK_RD;
               end else if (!cm_rdata_ff.passable) begin
                  state_ff <= S_POP;
               end else begin
                  state_ff <= S_NB;
               end
            end
            S_NB: begin
               if (nb_ok) begin
                  nb_ff     <= nb_addr;
                  nb_row_ff <= nb_row;
                  nb_col_ff <= nb_col;
                  state_ff  <= S_NB_D;
               end else if (k_ff == DIR_UP) begin
                  state_ff <= S_POP;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_NB_D: begin
               if (nb_free) begin
                  key_ff   <= '{pri: new_pri, node: nb_ff};
                  hole_ff  <= count_ff[CELL_W-1:0];
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_PU;
               end else if (k_ff == DIR_UP) begin
                  state_ff <= S_POP;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_NB;
               end
            end
            S_PU: begin
               if (hole_ff != '0) begin
                  state_ff <= S_PU_CMP;
               end else if (k_ff == DIR_UP) begin
                  state_ff <= S_POP;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_NB;
               end
            end
            S_PU_CMP: begin
               if (pu_move) begin
                  hole_ff  <= pu_parent;
                  state_ff <= S_PU;
               end else if (k_ff == DIR_UP) begin
                  state_ff <= S_POP;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_NB;
               end
            end
            S_WALK_RD: state_ff <= S_WALK_D;
            S_WALK_D: begin
               if ((cm_rdata_ff.parent == start_ff) || (steps_ff >= cells_ff)) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_next_cell_ff   <= walk_ff;
                  rsp_path_length_ff <= gcost_ff[CELL_W-1:0];
                  rsp_found_ff       <= 1'b1;
                  state_ff           <= S_IDLE;
               end else begin
                  walk_ff  <= cm_rdata_ff.parent;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_WALK_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_cell   = rsp_next_cell_ff;
   assign rsp_path_length = rsp_path_length_ff;
   assign rsp_found       = rsp_found_ff;

endmodule

`default_nettype wire

@@ rtl/gans_divider.sv @@
`default_nettype none

module gans_divider
   import gans_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [CELL_W-1:0] dividend,
   input  wire logic [CFG_W-1:0]  divisor,
   output logic                   done,
   output logic [CELL_W-1:0]      quotient,
   output logic [CFG_W-1:0]       remainder
);

   localparam int CNT_W = $clog2(CELL_W + 1);

   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [CELL_W-1:0] quo_ff;
   logic [CFG_W-1:0]  rem_ff;
   logic [CFG_W:0]    shifted;
   logic [CFG_W:0]    trial;

   assign shifted = {rem_ff, quo_ff[CELL_W-1]};
   assign trial   = shifted - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            cnt_ff <= CNT_W'(CELL_W);
            quo_ff <= dividend;
            rem_ff <= '0;
         end else if (cnt_ff != '0) begin
            if (shifted >= {1'b0, divisor}) begin
               rem_ff <= trial[CFG_W-1:0];
               quo_ff <= {quo_ff[CELL_W-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[CFG_W-1:0];
               quo_ff <= {quo_ff[CELL_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) done_ff <= 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ sim/grid_route_checker.sv @@
module grid_route_checker
   import gans_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   input  wire logic              pready,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic              req_type,
   input  wire logic [CELL_W-1:0] req_cell_index,
   input  wire logic              req_cell_open,
   input  wire logic [CELL_W-1:0] req_start_cell,
   input  wire logic [CELL_W-1:0] req_goal_cell,
   input  wire logic              rsp_valid,
   input  wire logic [CELL_W-1:0] rsp_next_cell,
   input  wire logic [CELL_W-1:0] rsp_path_length,
   input  wire logic              rsp_found,
   output int                     mismatches,
   output int                     routes_pending
);

   typedef struct packed {
      logic [CELL_W-1:0] next_cell;
      logic [CELL_W-1:0] path_length;
      logic              found;
   } route_answer_type;

   localparam longint unsigned NO_COST = 64'hFFFF_FFFF;

   route_answer_type route_q[$];
   logic [CFG_W-1:0] rows_reg;
   logic [CFG_W-1:0] cols_reg;
   bit               walkable[CELLS];
   longint unsigned  cost_of[CELLS];
   int unsigned      came_from[CELLS];
   longint unsigned  frontier[CELLS];
   int unsigned      frontier_n;

   assign routes_pending = route_q.size();

   function automatic int unsigned side_of(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
   endfunction

   function automatic int unsigned gap(input int unsigned a, input int unsigned b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic longint unsigned rank_key(input int unsigned node, input int unsigned goal,
                                                input int unsigned cols);
      longint unsigned h;
      h = gap(node / cols, goal / cols) + gap(node % cols, goal % cols);
      return ((cost_of[node] + h) << 20) | node;
   endfunction

   function automatic void frontier_push(input longint unsigned key);
      int unsigned i;
      int unsigned p;
      longint unsigned t;
      if (frontier_n >= CELLS) return;
      i = frontier_n;
      frontier_n++;
      frontier[i] = key;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (frontier[p] <= frontier[i]) break;
         t = frontier[p]; frontier[p] = frontier[i]; frontier[i] = t;
         i = p;
      end
   endfunction

   function automatic longint unsigned frontier_pop();
      longint unsigned top;
      longint unsigned t;
      int unsigned i;
      int unsigned l;
      int unsigned r;
      int unsigned s;
      top = frontier[0];
      i = 0;
      frontier_n--;
      frontier[0] = frontier[frontier_n];
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         s = i;
         if (l < frontier_n && frontier[l] < frontier[s]) s = l;
         if (r < frontier_n && frontier[r] < frontier[s]) s = r;
         if (s == i) break;
         t = frontier[s]; frontier[s] = frontier[i]; frontier[i] = t;
         i = s;
      end
      return top;
   endfunction

   function automatic route_answer_type plan_route(input int unsigned src,
                                                   input int unsigned dst);
      route_answer_type ans;
      int unsigned rows;
      int unsigned cols;
      int unsigned cells;
      int unsigned cur;
      int unsigned r;
      int unsigned c;
      int unsigned nb;
      int unsigned it;
      int unsigned steps;
      bit hit;
      bit ok;
      rows = side_of(rows_reg);
      cols = side_of(cols_reg);
      cells = rows * cols;
      if (cells > CELLS) cells = CELLS;
      ans.next_cell = CELL_W'(src);
      ans.path_length = '0;
      ans.found = 1'b0;
      if (src >= cells || dst >= cells) return ans;
      if (src == dst) begin
         ans.found = 1'b1;
         return ans;
      end
      for (int i = 0; i < CELLS; i++) cost_of[i] = NO_COST;
      frontier_n = 0;
      cost_of[src] = 0;
      frontier_push(rank_key(src, dst, cols));
      hit = 0;
      while (frontier_n > 0) begin
         cur = 32'(frontier_pop() & 64'hFFFFF);
         if (cur == dst) begin
            hit = 1;
            break;
         end
         if (cur >= cells || !walkable[cur]) continue;
         r = cur / cols;
         c = cur % cols;
         for (int k = 0; k < 4; k++) begin
            ok = 1;
            case (k)
               DIR_RIGHT: begin
                  ok = (c + 1 < cols) && (cur + 1 < cells);
                  nb = cur + 1;
               end
               DIR_LEFT: begin
                  ok = (c != 0);
                  nb = cur - 1;
               end
               DIR_DOWN: begin
                  ok = (r + 1 < rows) && (cur + cols < cells);
                  nb = cur + cols;
               end
               default: begin
                  ok = (r != 0);
                  nb = cur - cols;
               end
            endcase
            if (!ok) continue;
            if (!walkable[nb] || cost_of[nb] != NO_COST) continue;
            cost_of[nb] = cost_of[cur] + 1;
            came_from[nb] = cur;
            frontier_push(rank_key(nb, dst, cols));
         end
      end
      if (!hit) return ans;
      it = dst;
      steps = 0;
      while (came_from[it] != src && steps < cells) begin
         it = came_from[it] % CELLS;
         steps++;
      end
      ans.next_cell = CELL_W'(it);
      ans.path_length = CELL_W'(cost_of[dst]);
      ans.found = 1'b1;
      return ans;
   endfunction

   always @(posedge clock) begin
      route_answer_type want;
      int errs;
      errs = 0;
      if (reset) begin
         rows_reg <= CFG_W'(SIDE_MAX);
         cols_reg <= CFG_W'(SIDE_MAX);
         for (int i = 0; i < CELLS; i++) walkable[i] = 0;
         route_q.delete();
         mismatches <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_GRID_ROWS) rows_reg <= pwdata[CFG_W-1:0];
            else cols_reg <= pwdata[CFG_W-1:0];
         end
         if (start && !busy) begin
            if (req_type == REQ_LOAD) walkable[req_cell_index] = req_cell_open;
            else route_q.insert(route_q.size(), plan_route(req_start_cell, req_goal_cell));
         end
         if (rsp_valid) begin
            if (route_q.size() == 0) begin
               $error("result with no search request outstanding");
               errs = errs + 1;
            end else begin
               want = route_q.pop_front();
               if (rsp_next_cell !== want.next_cell) begin
                  $error("next_cell: expected %0d, got %0d", want.next_cell, rsp_next_cell);
                  errs = errs + 1;
               end
               if (rsp_path_length !== want.path_length) begin
                  $error("path_length: expected %0d, got %0d", want.path_length,
                         rsp_path_length);
                  errs = errs + 1;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  errs = errs + 1;
               end
            end
         end
         mismatches <= mismatches + errs;
      end
   end

endmodule

@@ sim/tb_grid_astar_next_step.sv @@
module tb_grid_astar_next_step;
   import gans_pkg::*;

   localparam int CYCLE_LIMIT = 20_000_000;

   logic              clock = 0;
   logic              reset = 1;
   logic              psel = 0;
   logic              penable = 0;
   logic              pwrite = 0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;
   logic              start = 0;
   logic              busy;
   logic              req_type = REQ_LOAD;
   logic [CELL_W-1:0] req_cell_index = '0;
   logic              req_cell_open = 0;
   logic [CELL_W-1:0] req_start_cell = '0;
   logic [CELL_W-1:0] req_goal_cell = '0;
   logic              rsp_valid;
   logic [CELL_W-1:0] rsp_next_cell;
   logic [CELL_W-1:0] rsp_path_length;
   logic              rsp_found;
   int                mismatches;
   int                routes_pending;
   int                burst_left = 0;
   longint            cycles = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   grid_astar_next_step dut (.*);

   grid_route_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic issue(input logic kind, input int unsigned a, input int unsigned b,
                        input int unsigned c);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if ($urandom_range(0, 3) != 0) begin
            start = 0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      start = 1;
      req_type = kind;
      req_cell_index = CELL_W'(a);
      req_cell_open = 1'(b);
      req_start_cell = CELL_W'(kind == REQ_SEARCH ? a : $urandom);
      req_goal_cell = CELL_W'(kind == REQ_SEARCH ? c : $urandom);
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic load_cell(input int unsigned idx, input bit open_cell);
      issue(REQ_LOAD, idx, open_cell, 0);
   endtask

   task automatic search(input int unsigned src, input int unsigned dst);
      issue(REQ_SEARCH, src, $urandom_range(0, 1), dst);
   endtask

   task automatic drain();
      start = 0;
      while (routes_pending != 0) @(negedge clock);
      while (busy) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel = 1;
      penable = 0;
      pwrite = 1;
      paddr = addr;
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
   endtask

   task automatic set_grid(input logic [31:0] rows, input logic [31:0] cols);
      drain();
      csr_write(3'd0, rows);
      csr_write(3'd4, cols);
   endtask

   initial begin
      int unsigned rows;
      int unsigned cols;
      int unsigned cells;
      repeat (8) @(negedge clock);
      reset = 0;

      set_grid(4, 5);
      for (int i = 0; i < 5; i++) load_cell(i, 1);
      load_cell(9, 1);
      load_cell(14, 1);
      load_cell(19, 1);
      load_cell(4095, 1);
      load_cell(4095, 0);
      search(0, 19);
      search(0, 4);
      search(2, 2);
      search(7, 7);
      search(7, 0);
      search(0, 12);
      search(0, 20);
      search(25, 0);
      search(4095, 4095);

      set_grid(0, 127);
      for (int i = 5; i < 10; i++) load_cell(i, 1);
      search(0, 9);
      search(9, 0);
      search(0, 63);

      set_grid(127, 0);
      search(0, 9);
      search(5, 2);

      set_grid(64, 64);
      load_cell(64, 1);
      load_cell(128, 1);
      search(128, 9);
      search(0, 4095);

      for (int ph = 0; ph < 3; ph++) begin
         rows = $urandom_range(2, 6);
         cols = $urandom_range(2, 6);
         cells = rows * cols;
         set_grid(rows, cols);
         for (int i = 0; i < cells; i++) load_cell(i, $urandom_range(0, 3) != 0);
         for (int i = 0; i < 6; i++) search($urandom_range(0, cells - 1),
                                            $urandom_range(0, cells - 1));
         load_cell($urandom, $urandom_range(0, 1));
         search($urandom, $urandom);
         if ($urandom_range(0, 1) != 0) search($urandom_range(0, cells - 1), $urandom);
      end

      drain();
      if (mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
